/* hw/rtl/skpm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the string key pair match table.
package skpm_pkg;

    localparam int LETTER_BITS          = 5;
    localparam int MAX_KEY_LETTERS      = 5;
    localparam int KEY_W                = LETTER_BITS * MAX_KEY_LETTERS;
    localparam int TAG_W                = 7;
    localparam int CNT_W                = 11;
    localparam int STATUS_W             = 2;
    localparam int HASH_BASE            = 29;
    localparam int DEF_NUM_BUCKETS      = 1024;
    localparam int DEF_SLOTS_PER_BUCKET = 10;
    localparam int BUCKET_COUNT_RESET   = 1024;
    localparam int LETTER_CNT_W         = $clog2(MAX_KEY_LETTERS + 1);
    // two quotient bits per cycle
    localparam int DIV_CYCLES           = (KEY_W + 1) / 2;
    localparam int DIV_W                = 2 * DIV_CYCLES;
    localparam int DIV_CNT_W            = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED,
        ST_MATCHED,
        ST_FULL,
        ST_EMPTY_KEY
    } status_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_HASH,
        FSM_DIV,
        FSM_BASE,
        FSM_SCAN,
        FSM_FINISH
    } fsm_state_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] row;
        logic [TAG_W-1:0] col;
    } slot_entry_t;

endpackage

/* hw/rtl/string_key_pair_match_table.sv */
`timescale 1ns / 1ps
// Top level: bucketed key table with hash, iterative modulo and slot scan.
//
//   channel  dir  handshake             beat contents
//   in       in   in_valid / in_stall   key_letters, tag_row, tag_col
//   out      out  out_valid / out_stall status, match_row, match_col
//   cfg      in   cfg_wr_en             cfg_wr_data (bucket_count)
//
// One item at a time: a hash step per letter position, iterative modulo steps (two
// remainder bits each), the bucket base, the slot reads and checks, loading the
// output and the idle state; an empty key goes straight to loading the output.
// After reset a pass clearing all NUM_BUCKETS*SLOTS_PER_BUCKET slots (10240) holds
// in_stall high. A result beat waits in the output register while out_stall is
// high; the next item is taken meanwhile, then in_stall stays high until it drains.
module string_key_pair_match_table #(
    parameter int NUM_BUCKETS      = skpm_pkg::DEF_NUM_BUCKETS,
    parameter int SLOTS_PER_BUCKET = skpm_pkg::DEF_SLOTS_PER_BUCKET
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [skpm_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [skpm_pkg::KEY_W-1:0]    key_letters,
    input  logic [skpm_pkg::TAG_W-1:0]    tag_row,
    input  logic [skpm_pkg::TAG_W-1:0]    tag_col,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [skpm_pkg::STATUS_W-1:0] status,
    output logic [skpm_pkg::TAG_W-1:0]    match_row,
    output logic [skpm_pkg::TAG_W-1:0]    match_col
);

    localparam int TOTAL = NUM_BUCKETS * SLOTS_PER_BUCKET;
    localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int RW    = $clog2(NUM_BUCKETS + 1);
    localparam int CW    = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int IW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int KW    = skpm_pkg::KEY_W;
    localparam int LB    = skpm_pkg::LETTER_BITS;
    localparam int TW    = skpm_pkg::TAG_W;

    // table RAM
    skpm_pkg::slot_entry_t mem [TOTAL];
    skpm_pkg::slot_entry_t mem_rdata_reg;
    skpm_pkg::slot_entry_t mem_wdata;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;

    // control
    skpm_pkg::fsm_state_t             state_reg, state_next;
    logic [AW-1:0]                    clr_cnt_reg, clr_cnt_next;
    logic [skpm_pkg::CNT_W-1:0]       bucket_count_reg;
    logic                             out_valid_reg, out_valid_next;

    // datapath
    logic [KW-1:0]                    key_reg, key_next;
    logic [KW-1:0]                    key_sh_reg, key_sh_next;
    logic [KW-1:0]                    hash_reg, hash_next;
    logic [skpm_pkg::LETTER_CNT_W-1:0] hash_cnt_reg, hash_cnt_next;
    logic [TW-1:0]                    row_reg, row_next;
    logic [TW-1:0]                    col_reg, col_next;
    logic [RW-1:0]                    mod_reg, mod_next;
    logic [RW-1:0]                    rem_reg, rem_next;
    logic [skpm_pkg::DIV_W-1:0]       div_sh_reg, div_sh_next;
    logic [skpm_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [AW-1:0]                    base_reg, base_next;
    logic [CW-1:0]                    rd_idx_reg, rd_idx_next;
    logic                             chk_vld_reg, chk_vld_next;
    logic [IW-1:0]                    chk_idx_reg, chk_idx_next;
    logic                             free_found_reg, free_found_next;
    logic [IW-1:0]                    free_idx_reg, free_idx_next;
    skpm_pkg::status_t                res_status_reg, res_status_next;
    logic [TW-1:0]                    res_row_reg, res_row_next;
    logic [TW-1:0]                    res_col_reg, res_col_next;
    skpm_pkg::status_t                status_reg, status_next;
    logic [TW-1:0]                    match_row_reg, match_row_next;
    logic [TW-1:0]                    match_col_reg, match_col_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= skpm_pkg::FSM_CLEAR;
            clr_cnt_reg      <= '0;
            bucket_count_reg <= skpm_pkg::CNT_W'(skpm_pkg::BUCKET_COUNT_RESET);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                bucket_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        key_sh_reg     <= key_sh_next;
        hash_reg       <= hash_next;
        hash_cnt_reg   <= hash_cnt_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        mod_reg        <= mod_next;
        rem_reg        <= rem_next;
        div_sh_reg     <= div_sh_next;
        div_cnt_reg    <= div_cnt_next;
        base_reg       <= base_next;
        rd_idx_reg     <= rd_idx_next;
        chk_vld_reg    <= chk_vld_next;
        chk_idx_reg    <= chk_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_row_reg    <= res_row_next;
        res_col_reg    <= res_col_next;
        status_reg     <= status_next;
        match_row_reg  <= match_row_next;
        match_col_reg  <= match_col_next;
    end

    always_comb
    begin
        logic          alive;
        logic [LB-1:0] letter;
        logic [RW:0]   part;
        logic [RW-1:0] rem_w;
        logic [skpm_pkg::DIV_W-1:0] sh_w;
        logic          is_hit;
        logic          any_free;
        logic [IW-1:0] ins_idx;

        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        out_valid_next  = out_valid_reg & out_stall;
        key_next        = key_reg;
        key_sh_next     = key_sh_reg;
        hash_next       = hash_reg;
        hash_cnt_next   = hash_cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        mod_next        = mod_reg;
        rem_next        = rem_reg;
        div_sh_next     = div_sh_reg;
        div_cnt_next    = div_cnt_reg;
        base_next       = base_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        res_status_next = res_status_reg;
        res_row_next    = res_row_reg;
        res_col_next    = res_col_reg;
        status_next     = status_reg;
        match_row_next  = match_row_reg;
        match_col_next  = match_col_reg;
        mem_we          = 1'b0;
        mem_waddr       = base_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = base_reg + AW'(rd_idx_reg);
        in_stall        = (state_reg != skpm_pkg::FSM_IDLE);

        alive    = 1'b1;
        letter   = '0;
        part     = '0;
        rem_w    = rem_reg;
        sh_w     = div_sh_reg;
        is_hit   = 1'b0;
        any_free = 1'b0;
        ins_idx  = '0;

        case (state_reg)
            skpm_pkg::FSM_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(TOTAL - 1))
                begin
                    state_next = skpm_pkg::FSM_IDLE;
                end
            end

            skpm_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    // codes after the first zero code are dropped
                    for (int i = 0; i < skpm_pkg::MAX_KEY_LETTERS; i++)
                    begin
                        letter = key_letters[KW-1-i*LB -: LB];
                        alive  = alive & (letter != '0);
                        key_next[KW-1-i*LB -: LB] = alive ? letter : '0;
                    end
                    key_sh_next   = key_next;
                    hash_next     = '0;
                    hash_cnt_next = '0;
                    row_next      = tag_row;
                    col_next      = tag_col;
                    if (bucket_count_reg == '0)
                    begin
                        mod_next = RW'(1);
                    end
                    else if (int'(bucket_count_reg) > NUM_BUCKETS)
                    begin
                        mod_next = RW'(NUM_BUCKETS);
                    end
                    else
                    begin
                        mod_next = RW'(bucket_count_reg);
                    end
                    res_row_next = '0;
                    res_col_next = '0;
                    if (key_letters[KW-1 -: LB] == '0)
                    begin
                        res_status_next = skpm_pkg::ST_EMPTY_KEY;
                        state_next      = skpm_pkg::FSM_FINISH;
                    end
                    else
                    begin
                        state_next = skpm_pkg::FSM_HASH;
                    end
                end
            end

            skpm_pkg::FSM_HASH:
            begin
                letter      = key_sh_reg[KW-1 -: LB];
                key_sh_next = key_sh_reg << LB;
                if (letter != '0)
                begin
                    hash_next = hash_reg * KW'(skpm_pkg::HASH_BASE) + KW'(letter);
                end
                hash_cnt_next = hash_cnt_reg + 1'b1;
                if (hash_cnt_reg == skpm_pkg::LETTER_CNT_W'(skpm_pkg::MAX_KEY_LETTERS - 1))
                begin
                    div_sh_next  = skpm_pkg::DIV_W'(hash_next);
                    rem_next     = '0;
                    div_cnt_next = '0;
                    state_next   = skpm_pkg::FSM_DIV;
                end
            end

            skpm_pkg::FSM_DIV:
            begin
                for (int s = 0; s < 2; s++)
                begin
                    part = {rem_w, sh_w[skpm_pkg::DIV_W-1]};
                    sh_w = sh_w << 1;
                    if (part >= {1'b0, mod_reg})
                    begin
                        part = part - {1'b0, mod_reg};
                    end
                    rem_w = part[RW-1:0];
                end
                rem_next     = rem_w;
                div_sh_next  = sh_w;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == skpm_pkg::DIV_CNT_W'(skpm_pkg::DIV_CYCLES - 1))
                begin
                    state_next = skpm_pkg::FSM_BASE;
                end
            end

            skpm_pkg::FSM_BASE:
            begin
                base_next       = AW'(rem_reg) * AW'(SLOTS_PER_BUCKET);
                rd_idx_next     = '0;
                free_found_next = 1'b0;
                free_idx_next   = '0;
                state_next      = skpm_pkg::FSM_SCAN;
            end

            skpm_pkg::FSM_SCAN:
            begin
                if (rd_idx_reg != CW'(SLOTS_PER_BUCKET))
                begin
                    mem_re       = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = IW'(rd_idx_reg);
                    rd_idx_next  = rd_idx_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    is_hit   = mem_rdata_reg.valid && (mem_rdata_reg.key == key_reg);
                    any_free = free_found_reg || !mem_rdata_reg.valid;
                    ins_idx  = free_found_reg ? free_idx_reg : chk_idx_reg;
                    if (!mem_rdata_reg.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = chk_idx_reg;
                    end
                    if (is_hit)
                    begin
                        mem_we          = 1'b1;
                        mem_waddr       = base_reg + AW'(chk_idx_reg);
                        mem_wdata       = mem_rdata_reg;
                        mem_wdata.valid = 1'b0;
                        res_status_next = skpm_pkg::ST_MATCHED;
                        res_row_next    = mem_rdata_reg.row;
                        res_col_next    = mem_rdata_reg.col;
                        chk_vld_next    = 1'b0;
                        state_next      = skpm_pkg::FSM_FINISH;
                    end
                    else if (chk_idx_reg == IW'(SLOTS_PER_BUCKET - 1))
                    begin
                        if (any_free)
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = base_reg + AW'(ins_idx);
                            mem_wdata.valid = 1'b1;
                            mem_wdata.key   = key_reg;
                            mem_wdata.row   = row_reg;
                            mem_wdata.col   = col_reg;
                            res_status_next = skpm_pkg::ST_INSERTED;
                        end
                        else
                        begin
                            res_status_next = skpm_pkg::ST_FULL;
                        end
                        chk_vld_next = 1'b0;
                        state_next   = skpm_pkg::FSM_FINISH;
                    end
                end
            end

            skpm_pkg::FSM_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    match_row_next = res_row_reg;
                    match_col_next = res_col_reg;
                    state_next     = skpm_pkg::FSM_IDLE;
                end
            end

            default:
            begin
                state_next = skpm_pkg::FSM_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign match_row = match_row_reg;
    assign match_col = match_col_reg;

endmodule

/* hw/rtl/skpm_chk.sv */
`timescale 1ns / 1ps
// Port checker for the string key pair match table, bound to the top level.
module skpm_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [skpm_pkg::STATUS_W-1:0] status,
    input logic [skpm_pkg::TAG_W-1:0]    match_row,
    input logic [skpm_pkg::TAG_W-1:0]    match_col
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(match_row) && $stable(match_col))
        else $error("stalled result beat changed");

    // one item in flight: the input closes right after a beat is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while one is in flight");

    // tags are zero unless the beat reports a match
    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 2'(skpm_pkg::ST_MATCHED))
            |-> (match_row == '0) && (match_col == '0))
        else $error("tag shown on a result without a match");

    // a new result only comes out of a busy block
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat appeared while the block was idle");

endmodule

bind string_key_pair_match_table skpm_chk u_skpm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .match_row (match_row),
    .match_col (match_col)
);
